// ----- hw/rtl/lbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants of the letterbox bilinear scaler.
// ----------------------------------------------------------------------------
package lbs_pkg;
  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int MaxPlanes = 3;
  localparam int StoreDepth = MaxWidth * MaxHeight * MaxPlanes;
  localparam int AddrW = $clog2(StoreDepth);
  localparam logic [15:0] FillValue = 16'd32768;

  localparam logic [2:0] RegSw = 3'd0;
  localparam logic [2:0] RegSh = 3'd1;
  localparam logic [2:0] RegTw = 3'd2;
  localparam logic [2:0] RegTh = 3'd3;
  localparam logic [2:0] RegCh = 3'd4;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdRead = 1'b1;

  // Effective (clamped) dimensions handed from the register file.
  typedef struct packed {
    logic [9:0] sw;
    logic [9:0] sh;
    logic [9:0] tw;
    logic [9:0] th;
    logic [1:0] ch;
  } dims_t;

  // Clamp a dimension register to 1..hi.
  function automatic logic [9:0] clamp_dim(input logic [9:0] v, input logic [9:0] hi);
    logic [9:0] r;
    r = v;
    if (v == 10'd0) r = 10'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction
endpackage

// ----- hw/rtl/lbs_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_stream_if
// Valid/ready channels for commands and pixels.
// ----------------------------------------------------------------------------
interface lbs_cmd_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] sample;
  modport source (output valid, command, sample, input ready);
  modport sink (input valid, command, sample, output ready);
endinterface

interface lbs_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic        frame_last;
  modport source (output valid, pixel_value, frame_last, input ready);
  modport sink (input valid, pixel_value, frame_last, output ready);
endinterface

// ----- hw/rtl/lbs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // One access per cycle: write or read.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- hw/rtl/lbs_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_divider
// Restoring divider, one quotient bit per cycle, 26-bit dividend.
// ----------------------------------------------------------------------------
module lbs_divider import lbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [25:0] dividend,
  input  logic [19:0] divisor,
  output logic        done,
  output logic [25:0] quotient
);
  logic [4:0]  count;
  logic        busy;
  logic [20:0] rem;
  logic [25:0] quo;
  logic [19:0] dvs;
  logic [20:0] trial;

  assign trial = {rem[19:0], quo[25]} - {1'b0, dvs};

  // Shift and subtract each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 5'd0;
        rem <= 21'd0;
        quo <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        if (!trial[20]) rem <= trial;
        else rem <= {rem[19:0], quo[25]};
        quo <= {quo[24:0], ~trial[20]};
        count <= count + 5'd1;
        if (count == 5'd25) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quotient = quo;
endmodule

// ----- hw/rtl/lbs_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_regs
// APB register file holding the image dimensions.
// ----------------------------------------------------------------------------
module lbs_regs import lbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output dims_t       dims
);
  logic [9:0] sw, sh, tw, th;
  logic [1:0] ch;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[4:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= 10'd320;
      sh <= 10'd320;
      tw <= 10'd416;
      th <= 10'd416;
      ch <= 2'd3;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegSw: sw <= pwdata[9:0];
        RegSh: sh <= pwdata[9:0];
        RegTw: tw <= pwdata[9:0];
        RegTh: th <= pwdata[9:0];
        RegCh: ch <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Readback.
  always_comb begin
    case (idx)
      RegSw: prdata = {22'd0, sw};
      RegSh: prdata = {22'd0, sh};
      RegTw: prdata = {22'd0, tw};
      RegTh: prdata = {22'd0, th};
      RegCh: prdata = {30'd0, ch};
      default: prdata = 32'd0;
    endcase
  end

  assign dims.sw = clamp_dim(sw, 10'(MaxWidth));
  assign dims.sh = clamp_dim(sh, 10'(MaxHeight));
  assign dims.tw = clamp_dim(tw, 10'(MaxWidth));
  assign dims.th = clamp_dim(th, 10'(MaxHeight));
  assign dims.ch = (ch == 2'd0) ? 2'd1 : ((ch > 2'(MaxPlanes)) ? 2'(MaxPlanes) : ch);
endmodule

// ----- hw/rtl/letterbox_bilinear_scaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letterbox_bilinear_scaler
// Letterbox resize of a planar 8-bit image by separable bilinear filtering.
// ----------------------------------------------------------------------------
// Usage: each transaction on the command channel is a load (command 0),
// which writes one source byte into the frame store in plane, row, column
// order, or a read (command 1), which produces one target pixel on the pixel
// channel, also in plane, row, column order. frame_last marks the last pixel.
// A load is taken without leaving the idle state, so loads can follow back
// to back while no pixel waits in the output register. A read computes its
// pixel in steps: the box size comes from a bit-serial divider, then the
// four source samples of a pixel are read one per cycle from the single-port
// frame store, followed by two blend steps with a register after each. The
// first read of a frame also computes the two scales with the same divider.
// Reset returns the registers to 320x320 source, 416x416 target, 3 planes,
// and zeroes the load and emit positions; the frame store is not cleared and
// must be loaded before it is read. When the receiver stalls, the finished
// pixel waits in the output register and the next command is accepted in the
// cycle after it is taken.
// ----------------------------------------------------------------------------
module letterbox_bilinear_scaler import lbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lbs_cmd_if.sink     cmd,
  lbs_pix_if.source   pix,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StBox   = 4'd1;
  localparam logic [3:0] StDivH  = 4'd2;
  localparam logic [3:0] StWaitH = 4'd3;
  localparam logic [3:0] StDivV  = 4'd4;
  localparam logic [3:0] StWaitV = 4'd5;
  localparam logic [3:0] StCoord = 4'd6;
  localparam logic [3:0] StMulY  = 4'd7;
  localparam logic [3:0] StFetch = 4'd8;
  localparam logic [3:0] StBlendA = 4'd9;
  localparam logic [3:0] StBlendB = 4'd10;
  localparam logic [3:0] StBlendC = 4'd11;
  localparam logic [3:0] StOut   = 4'd12;
  localparam logic [3:0] StDivB  = 4'd13;
  localparam logic [3:0] StWaitB = 4'd14;

  dims_t dims;
  lbs_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .dims(dims)
  );

  logic [3:0]  state;
  logic [AddrW-1:0] load_pos;
  logic [1:0]  eplane;
  logic [9:0]  erow, ecol;
  logic [31:0] hscale, vscale;
  logic [9:0]  nw, nh;
  logic        wide;
  logic [19:0] prod_a, prod_b;

  // Divider shared by box size and scales.
  logic        div_start, div_done;
  logic [25:0] div_n, div_q;
  logic [19:0] div_d;
  lbs_divider u_div (
    .clk, .rst, .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quotient(div_q)
  );

  // Frame store.
  logic              ram_we;
  logic [AddrW-1:0]  ram_addr;
  logic [7:0]        ram_rdata;
  lbs_ram #(.Width(8), .Depth(StoreDepth)) u_store (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(cmd.sample), .rdata(ram_rdata)
  );

  logic [AddrW-1:0] total;
  logic [AddrW-1:0] lp_eff;
  assign total = AddrW'(dims.sw * dims.sh * dims.ch);
  assign lp_eff = (load_pos >= total) ? '0 : load_pos;

  assign cmd.ready = (state == StIdle) && !pix.valid;
  logic acc;
  assign acc = cmd.valid && cmd.ready;

  // Per-pixel working registers.
  logic        fill, hedge, vsolo;
  logic [9:0]  ix0, ix1, iy0, iy1, lx, ly;
  logic [15:0] dx, dy;
  logic [41:0] sx, sy;
  logic [1:0]  fetch_n;
  logic [15:0] s00, s01, s10, s11;
  logic [15:0] top, bot;
  logic [9:0]  ox, oy;
  logic [11:0] pbase;

  // Store address for each of the four fetches.
  logic [9:0]  fy, fx;
  logic [AddrW-1:0] raddr;
  always_comb begin
    fy = fetch_n[1] ? iy1 : iy0;
    fx = fetch_n[0] ? ix1 : ix0;
    raddr = (AddrW'(pbase) + AddrW'(fy)) * AddrW'(dims.sw) + AddrW'(fx);
  end
  assign ram_we = acc && (cmd.command == CmdLoad);
  assign ram_addr = ram_we ? lp_eff : raddr;

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] f);
    logic [34:0] v;
    v = 35'((17'd65536 - 17'(f)) * a) + 35'(f * b) + 35'd32768;
    return v[31:16];
  endfunction

  logic [9:0] nh_m1, nw_m1;
  assign nh_m1 = nh - 10'd1;
  assign nw_m1 = nw - 10'd1;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      load_pos <= '0;
      eplane <= 2'd0;
      erow <= 10'd0;
      ecol <= 10'd0;
      hscale <= 32'd0;
      vscale <= 32'd0;
      pix.valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (pix.valid && pix.ready) pix.valid <= 1'b0;
      case (state)
        StIdle: begin
          if (acc && cmd.command == CmdLoad) begin
            load_pos <= (lp_eff + 1'b1 >= total) ? '0 : lp_eff + 1'b1;
          end else if (acc) begin
            prod_a <= 20'(dims.tw * dims.sh);
            prod_b <= 20'(dims.th * dims.sw);
            state <= StBox;
          end
        end
        StBox: begin
          // Box size: one dimension is the target, the other a quotient.
          wide <= prod_a < prod_b;
          div_n <= (prod_a < prod_b) ? 26'(dims.sh * dims.tw) : 26'(dims.sw * dims.th);
          div_d <= (prod_a < prod_b) ? 20'(dims.sw) : 20'(dims.sh);
          div_start <= 1'b1;
          state <= StDivB;
        end
        StDivB: state <= StWaitB;
        StWaitB: if (div_done) begin
          if (wide) begin nw <= dims.tw; nh <= div_q[9:0]; end
          else begin nh <= dims.th; nw <= div_q[9:0]; end
          state <= (eplane == 2'd0 && erow == 10'd0 && ecol == 10'd0) ? StDivH : StCoord;
        end
        StDivH: begin
          div_n <= {dims.sw - 10'd1, 16'd0};
          div_d <= 20'(nw_m1);
          div_start <= (nw > 10'd1);
          if (nw <= 10'd1) begin hscale <= 32'd0; state <= StDivV; end
          else state <= StWaitH;
        end
        StWaitH: if (div_done) begin
          hscale <= 32'(div_q);
          state <= StDivV;
        end
        StDivV: begin
          div_n <= {dims.sh - 10'd1, 16'd0};
          div_d <= 20'(nh_m1);
          div_start <= (nh > 10'd1);
          if (nh <= 10'd1) begin vscale <= 32'd0; state <= StCoord; end
          else state <= StWaitV;
        end
        StWaitV: if (div_done) begin
          vscale <= 32'(div_q);
          state <= StCoord;
        end
        StCoord: begin
          // Box offsets and the first row of the plane.
          ox <= (dims.tw - nw) >> 1;
          oy <= (dims.th - nh) >> 1;
          pbase <= 12'(eplane) * 12'(dims.sh);
          state <= StMulY;
        end
        StMulY: begin
          lx <= ecol - ox;
          ly <= erow - oy;
          fill <= (eplane >= dims.ch) || (erow >= dims.th) || (ecol >= dims.tw) ||
                  (nw == 10'd0) || (nh == 10'd0) || (ecol < ox) ||
                  (11'(ecol) >= 11'(ox) + 11'(nw)) || (erow < oy) ||
                  (11'(erow) >= 11'(oy) + 11'(nh));
          sx <= 42'({ecol - ox}) * 42'(hscale);
          sy <= 42'({erow - oy}) * 42'(vscale);
          state <= StFetch;
          fetch_n <= 2'd0;
          // Coordinates resolved in the next cycle below.
          ix0 <= 10'd0;
        end
        StFetch: begin
          state <= StBlendA;
        end
        default: ;
      endcase

      // Index pipeline.
      if (state == StFetch) begin
        hedge <= (lx == nw_m1) || (dims.sw == 10'd1);
        vsolo <= (ly == nh_m1) || (dims.sh == 10'd1);
        if (lx == nw_m1 || dims.sw == 10'd1) begin
          ix0 <= dims.sw - 10'd1;
          ix1 <= dims.sw - 10'd1;
          dx <= 16'd0;
        end else begin
          ix0 <= (sx[41:16] >= 26'(dims.sw)) ? dims.sw - 10'd1 : sx[25:16];
          ix1 <= (sx[41:16] + 26'd1 >= 26'(dims.sw)) ? dims.sw - 10'd1 : sx[25:16] + 10'd1;
          dx <= sx[15:0];
        end
        if (nh > 10'd1 && ly == nh_m1) begin
          iy0 <= dims.sh - 10'd1;
          iy1 <= dims.sh - 10'd1;
          dy <= 16'd0;
        end else begin
          iy0 <= (sy[41:16] >= 26'(dims.sh)) ? dims.sh - 10'd1 : sy[25:16];
          iy1 <= (sy[41:16] + 26'd1 >= 26'(dims.sh)) ? dims.sh - 10'd1 : sy[25:16] + 10'd1;
          dy <= sy[15:0];
        end
      end

      // Four reads: address in one cycle, data in the next.
      if (state == StBlendA) begin
        fetch_n <= fetch_n + 2'd1;
        case (fetch_n)
          2'd1: s00 <= {ram_rdata, ram_rdata};
          2'd2: s01 <= {ram_rdata, ram_rdata};
          2'd3: s10 <= {ram_rdata, ram_rdata};
          default: ;
        endcase
        if (fetch_n == 2'd3) state <= StBlendB;
      end
      if (state == StBlendB) begin
        s11 <= {ram_rdata, ram_rdata};
        state <= StBlendC;
      end
      if (state == StBlendC) begin
        top <= hedge ? s00 : blend(s00, s01, dx);
        bot <= hedge ? s10 : blend(s10, s11, dx);
        state <= StOut;
      end
      if (state == StOut) begin
        pix.pixel_value <= fill ? FillValue : (vsolo ? blend(top, 16'd0, dy)
                                                     : blend(top, bot, dy));
        pix.valid <= 1'b1;
        pix.frame_last <= (ecol + 10'd1 >= dims.tw) && (erow + 10'd1 >= dims.th) &&
                          (eplane + 2'd1 >= dims.ch);
        if (ecol + 10'd1 >= dims.tw) begin
          ecol <= 10'd0;
          if (erow + 10'd1 >= dims.th) begin
            erow <= 10'd0;
            eplane <= (eplane + 2'd1 >= dims.ch) ? 2'd0 : eplane + 2'd1;
          end else erow <= erow + 10'd1;
        end else ecol <= ecol + 10'd1;
        state <= StIdle;
      end
    end
  end
endmodule

// ----- verif/tb_letterbox_bilinear_scaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_letterbox_bilinear_scaler
// Self-checking testbench of the letterbox bilinear scaler.
// ----------------------------------------------------------------------------
// Each phase programs the image geometry over the APB port while the block is
// idle, loads the whole source image, and then mixes further loads with pixel
// reads. A behavioral scaler inside the testbench computes every pixel when
// its read is accepted, and the pixel monitor compares each pixel transaction
// with the oldest predicted pixel. The sender works in bursts and the receiver
// stalls on a pattern of its own, with one long hold-off. A directed part
// covers extreme geometries; random phases follow.
// ----------------------------------------------------------------------------
module tb_letterbox_bilinear_scaler;
  import lbs_pkg::*;

  typedef struct {
    logic       command;
    logic [7:0] sample;
  } cmd_item_t;

  typedef struct {
    logic [15:0] pixel_value;
    logic        frame_last;
  } pixel_item_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lbs_cmd_if cmd_ch ();
  lbs_pix_if pix_ch ();

  letterbox_bilinear_scaler u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch.sink),
    .pix     (pix_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Pending commands, predicted pixels and bookkeeping.
  cmd_item_t   cmd_q[$];
  pixel_item_t pixel_q[$];
  int unsigned mismatch_count;
  int unsigned item_count;
  bit          cmd_taken;
  bit          hold_off;
  bit          random_on;

  // Shadow of the registers and of the scaler state.
  logic [9:0]  src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  logic [1:0]  planes_reg;
  bit [7:0]    frame_mem [StoreDepth];
  int unsigned load_pos;
  int unsigned out_plane, out_row, out_col;
  int unsigned h_step, v_step;

  // Clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned src_w();
    return clamp_size(src_w_reg, MaxWidth);
  endfunction
  function automatic int unsigned src_h();
    return clamp_size(src_h_reg, MaxHeight);
  endfunction
  function automatic int unsigned dst_w();
    return clamp_size(dst_w_reg, MaxWidth);
  endfunction
  function automatic int unsigned dst_h();
    return clamp_size(dst_h_reg, MaxHeight);
  endfunction
  function automatic int unsigned planes();
    return clamp_size(planes_reg, MaxPlanes);
  endfunction

  // Size of the letterbox that keeps the source aspect ratio.
  function automatic void letterbox_size(output int unsigned bw, output int unsigned bh);
    if (dst_w() * src_h() < dst_h() * src_w()) begin
      bw = dst_w();
      bh = (src_h() * dst_w()) / src_w();
    end else begin
      bh = dst_h();
      bw = (src_w() * dst_h()) / src_h();
    end
  endfunction

  function automatic int unsigned lerp(longint unsigned a, longint unsigned b,
                                       longint unsigned f);
    longint unsigned v;
    v = (65536 - f) * a + f * b + 32768;
    return int'(v >> 16);
  endfunction

  function automatic int unsigned source_sample(int unsigned k, int unsigned y,
                                                int unsigned x);
    int unsigned idx;
    if (x >= src_w()) x = src_w() - 1;
    if (y >= src_h()) y = src_h() - 1;
    idx = (k * src_h() + y) * src_w() + x;
    if (idx >= StoreDepth) idx = StoreDepth - 1;
    return frame_mem[idx] * 257;
  endfunction

  // Horizontal pass over one source row.
  function automatic int unsigned row_lerp(int unsigned k, int unsigned y,
                                           int unsigned lx, int unsigned bw);
    longint unsigned sx;
    int unsigned     ix;
    if (lx == bw - 1 || src_w() == 1) return source_sample(k, y, src_w() - 1);
    sx = longint'(lx) * h_step;
    ix = (sx >> 16) >= src_w() ? src_w() - 1 : int'(sx >> 16);
    return lerp(source_sample(k, y, ix), source_sample(k, y, ix + 1), sx & 16'hFFFF);
  endfunction

  function automatic int unsigned scaled_pixel(int unsigned k, int unsigned r,
                                               int unsigned c);
    int unsigned     bw, bh, ox, oy, lx, ly, iy, dy, upper;
    longint unsigned sy;
    if (k >= planes() || r >= dst_h() || c >= dst_w()) return FillValue;
    letterbox_size(bw, bh);
    if (bw == 0 || bh == 0) return FillValue;
    ox = (dst_w() - bw) / 2;
    oy = (dst_h() - bh) / 2;
    if (c < ox || c >= ox + bw || r < oy || r >= oy + bh) return FillValue;
    lx = c - ox;
    ly = r - oy;
    // The last box row lands exactly on the last source row.
    if (bh > 1 && ly == bh - 1) begin
      iy = src_h() - 1;
      dy = 0;
    end else begin
      sy = longint'(ly) * v_step;
      iy = (sy >> 16) >= src_h() ? src_h() - 1 : int'(sy >> 16);
      dy = int'(sy & 16'hFFFF);
    end
    upper = row_lerp(k, iy, lx, bw);
    if (ly == bh - 1 || src_h() == 1) return lerp(upper, 0, dy);
    return lerp(upper, row_lerp(k, iy + 1, lx, bw), dy);
  endfunction

  // Applies one accepted command to the shadow state.
  task automatic apply_command(cmd_item_t it);
    int unsigned total, bw, bh;
    pixel_item_t px;
    if (it.command == CmdLoad) begin
      total = src_w() * src_h() * planes();
      if (load_pos >= total) load_pos = 0;
      frame_mem[load_pos] = it.sample;
      load_pos++;
      if (load_pos >= total) load_pos = 0;
    end else begin
      // Scales are latched by the first read of a frame.
      if (out_plane == 0 && out_row == 0 && out_col == 0) begin
        letterbox_size(bw, bh);
        h_step = bw > 1 ? ((src_w() - 1) << 16) / (bw - 1) : 0;
        v_step = bh > 1 ? ((src_h() - 1) << 16) / (bh - 1) : 0;
      end
      px.pixel_value = 16'(scaled_pixel(out_plane, out_row, out_col));
      px.frame_last = 1'b0;
      out_col++;
      if (out_col >= dst_w()) begin
        out_col = 0;
        out_row++;
        if (out_row >= dst_h()) begin
          out_row = 0;
          out_plane++;
          if (out_plane >= planes()) begin
            out_plane = 0;
            px.frame_last = 1'b1;
          end
        end
      end
      pixel_q.push_back(px);
    end
  endtask

  // Command driver: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      apply_command(cmd_q[0]);
      void'(cmd_q.pop_front());
      cmd_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!(cmd_ch.valid && !cmd_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_ch.valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd_q[0].command;
        cmd_ch.sample  <= cmd_q[0].sample;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
    cmd_taken = 1'b0;
  end

  // Pixel receiver: always ready, random, or mostly stalled, with the mode picked anew at random.
  int unsigned rx_mode = 0;
  int unsigned rx_cycles = 0;

  always @(negedge clk) begin
    if (rx_cycles == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_cycles = 50;
    end
    rx_cycles--;
    if (hold_off) pix_ch.ready <= 1'b0;
    else if (rx_mode == 0) pix_ch.ready <= 1'b1;
    else if (rx_mode == 1) pix_ch.ready <= 1'($urandom_range(0, 1));
    else pix_ch.ready <= ($urandom_range(0, 3) == 0);
  end

  // One long hold-off of the receiver, starting when a read is offered, while
  // commands keep coming.
  initial begin
    hold_off = 1'b0;
    wait (random_on);
    while (!(cmd_q.size() > 0 && cmd_q[0].command == CmdRead)) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // Pixel monitor.
  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pixel_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected pixel %0d last %0d", pix_ch.pixel_value,
                   pix_ch.frame_last);
      end else begin
        if (pix_ch.pixel_value !== pixel_q[0].pixel_value ||
            pix_ch.frame_last !== pixel_q[0].frame_last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: pixel expected %0d last %0d, got %0d last %0d",
                     pixel_q[0].pixel_value, pixel_q[0].frame_last,
                     pix_ch.pixel_value, pix_ch.frame_last);
        end
        void'(pixel_q.pop_front());
      end
    end
  end

  // APB register write: setup cycle then access cycle.
  task automatic write_reg(logic [2:0] idx, logic [9:0] value);
    logic [31:0] word;
    word = $urandom;
    if (idx == RegCh) word[1:0] = value[1:0];
    else word[9:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      RegSw: src_w_reg = word[9:0];
      RegSh: src_h_reg = word[9:0];
      RegTw: dst_w_reg = word[9:0];
      RegTh: dst_h_reg = word[9:0];
      default: planes_reg = word[1:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every command is taken and every pixel has arrived.
  task automatic drain();
    while (cmd_q.size() != 0 || pixel_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One phase: program, load the whole image, then mix loads and reads.
  task automatic run_phase(logic [9:0] sw, logic [9:0] sh, logic [9:0] tw,
                           logic [9:0] th, logic [1:0] ch, int unsigned n_mix);
    cmd_item_t   it;
    int unsigned total;
    drain();
    write_reg(RegSw, sw);
    write_reg(RegSh, sh);
    write_reg(RegTw, tw);
    write_reg(RegTh, th);
    write_reg(RegCh, ch);
    total = src_w() * src_h() * planes();
    for (int unsigned i = 0; i < total; i++) begin
      it.command = CmdLoad;
      it.sample = 8'($urandom);
      cmd_q.push_back(it);
    end
    for (int unsigned i = 0; i < n_mix; i++) begin
      it.command = ($urandom_range(0, 9) < 3) ? CmdLoad : CmdRead;
      it.sample = 8'($urandom);
      cmd_q.push_back(it);
      // Midway through, the sender sometimes waits for every pixel to come back.
      if (i == n_mix / 2 && $urandom_range(0, 3) == 0) drain();
    end
    item_count += total + n_mix;
  endtask

  function automatic logic [9:0] random_size(int unsigned hi);
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 10'd0;
    return 10'($urandom_range(1, hi));
  endfunction

  // Stimulus.
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CmdLoad;
    cmd_ch.sample = '0;
    pix_ch.ready = 1'b0;
    random_on = 1'b0;
    mismatch_count = 0;
    item_count = 0;
    cmd_taken = 1'b0;
    src_w_reg = 10'd320;
    src_h_reg = 10'd320;
    dst_w_reg = 10'd416;
    dst_h_reg = 10'd416;
    planes_reg = 2'd3;
    load_pos = 0;
    out_plane = 0;
    out_row = 0;
    out_col = 0;
    h_step = 0;
    v_step = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: single-pixel box, empty box, single source column,
    // tallest source with out-of-range register values, widest target,
    // tallest target with an empty box.
    run_phase(10'd1, 10'd1, 10'd1, 10'd1, 2'd1, 3);
    run_phase(10'd8, 10'd1, 10'd1, 10'd4, 2'd1, 5);
    run_phase(10'd1, 10'd4, 10'd3, 10'd6, 2'd2, 10);
    run_phase(10'd0, 10'd1023, 10'd0, 10'd1023, 2'd0, 6);
    run_phase(10'd40, 10'd1, 10'd512, 10'd2, 2'd3, 8);
    run_phase(10'd16, 10'd0, 10'd1, 10'd512, 2'd1, 6);

    // Random phases, often crossing frame boundaries.
    random_on = 1'b1;
    while (item_count < 1000) begin
      run_phase(random_size(10), random_size(10),
                ($urandom_range(0, 15) == 0) ? 10'($urandom_range(513, 1023))
                                             : random_size(12),
                random_size(12), 2'($urandom_range(0, 3)),
                $urandom_range(20, 150));
    end
    drain();
    if (mismatch_count == 0 && pixel_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule
